// ===== hdl/pve_pkg.sv =====
// Package for the plant viability evaluator: shared types, codes and the
// fixed-point falloff function 0.2^(u^4.5) used to build the lookup ROM.
// Depends on nothing.
package pve_pkg;

  typedef logic signed [23:0] meas_t;   // Q15.8
  typedef logic signed [15:0] flr_t;    // Q1.15
  typedef logic signed [16:0] viab_t;   // Q1.15 with headroom for +1.0
  typedef logic        [16:0] fnv_t;    // table value, 0..32768

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  localparam int NUM_RES = 4;
  localparam int NUM_SEL = 2 * NUM_RES;

  // pipeline control handed to every lane
  typedef struct packed {
    logic adv;
    logic vld;
  } pve_ctl_t;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned EXP_K   = 64'd3443211;
  localparam longint unsigned LN2_Q30 = 64'd744261118;

  function automatic longint unsigned isqrt64(longint unsigned x);
    longint unsigned r;
    longint unsigned bt;
    longint unsigned rem;
    r   = 0;
    bt  = 64'd1 << 62;
    rem = x;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r   = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // series term divided by its index, divisors fixed
  function automatic longint unsigned div_small(longint unsigned x, int k);
    longint unsigned q;
    case (k)
      1:       q = x;
      2:       q = x / 2;
      3:       q = x / 3;
      4:       q = x / 4;
      5:       q = x / 5;
      6:       q = x / 6;
      7:       q = x / 7;
      8:       q = x / 8;
      9:       q = x / 9;
      10:      q = x / 10;
      11:      q = x / 11;
      12:      q = x / 12;
      default: q = x;
    endcase
    return q;
  endfunction

  // t is u/2 in Q30; result is Q1.15 rounded
  function automatic fnv_t fn_value(longint unsigned t);
    longint unsigned t2;
    longint unsigned t4;
    longint unsigned s;
    longint unsigned w;
    longint unsigned z;
    longint unsigned n;
    longint unsigned fr;
    longint unsigned a;
    longint unsigned term;
    longint          e;
    longint unsigned v;
    t2   = (t * t) >> 30;
    t4   = (t2 * t2) >> 30;
    s    = isqrt64(t << 30);
    w    = (t4 * s) >> 30;
    z    = (w * EXP_K) >> 16;
    n    = z >> 30;
    fr   = z & (Q30_ONE - 1);
    a    = (fr * LN2_Q30) >> 30;
    term = Q30_ONE;
    e    = longint'(Q30_ONE);
    for (int k = 1; k <= 12; k++) begin
      term = div_small((term * a) >> 30, k);
      if (k % 2 == 1) e = e - longint'(term);
      else            e = e + longint'(term);
    end
    if (e < 0) e = 0;
    v = (n >= 31) ? 64'd0 : (unsigned'(e) >> n);
    return fnv_t'((v + (64'd1 << 14)) >> 15);
  endfunction

endpackage

// ===== hdl/pve_if.sv =====
// Handshake channels of the evaluator: input items and result items.
// Depends on pve_pkg.
interface pve_in_if import pve_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  opcode;
  logic  [5:0] species;
  logic  [2:0] param_select;
  meas_t param_value;
  meas_t sunlight;
  meas_t moisture;
  meas_t temperature;
  meas_t terrain_slope;
  flr_t  stress_floor;

  modport source (output valid, opcode, species, param_select, param_value, sunlight,
                  moisture, temperature, terrain_slope, stress_floor, input ready);
  modport sink   (input valid, opcode, species, param_select, param_value, sunlight,
                  moisture, temperature, terrain_slope, stress_floor, output ready);
endinterface

interface pve_out_if import pve_pkg::*; ();
  logic  valid;
  logic  ready;
  viab_t sun_viability;
  viab_t moisture_viability;
  viab_t temperature_viability;
  viab_t slope_viability;
  viab_t least_viability;

  modport source (output valid, sun_viability, moisture_viability, temperature_viability,
                  slope_viability, least_viability, input ready);
  modport sink   (input valid, sun_viability, moisture_viability, temperature_viability,
                  slope_viability, least_viability, output ready);
endinterface

// ===== hdl/pve_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pve_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pve_lane.sv =====
// One resource lane: difference, scaling, pipelined restoring divide,
// falloff ROM lookup and floor mix. Depends on pve_pkg.
module pve_lane import pve_pkg::*; #(
  parameter int FN_TABLE_DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  pve_ctl_t ctl,
  input  meas_t    x,
  input  meas_t    c,
  input  meas_t    r,
  input  flr_t     flr,
  output logic     vld,
  output viab_t    viab
);

  localparam int QW = $clog2(FN_TABLE_DEPTH);
  localparam int NW = 25 + QW;

  typedef fnv_t rom_t [FN_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t tab;
    for (int i = 0; i < FN_TABLE_DEPTH; i++) begin
      tab[i] = fn_value((64'(i) << 30) / 64'(FN_TABLE_DEPTH));
    end
    return tab;
  endfunction

  localparam rom_t FN_ROM = build_rom();

  // stage A: difference
  logic signed [24:0] d_r;
  logic [22:0]        ra_r;
  logic               rpos_r;
  flr_t               flra_r;
  logic               va_r;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      d_r    <= 25'(x) - 25'(c);
      ra_r   <= r[22:0];
      rpos_r <= (r > 24'sd0);
      flra_r <= flr;
    end
  end

  // stage B feeds the divider chain at index 0
  logic [24:0] ad;
  assign ad = d_r[24] ? (~d_r + 25'd1) : d_r;

  logic [NW-1:0] rem_r  [QW+1];
  logic [QW-1:0] q_r    [QW+1];
  logic [22:0]   rd_r   [QW+1];
  logic          ok_r   [QW+1];
  flr_t          flrd_r [QW+1];
  logic          vd_r   [QW+1];

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rem_r[0]  <= NW'(ad) * NW'(FN_TABLE_DEPTH);
      q_r[0]    <= '0;
      rd_r[0]   <= ra_r;
      ok_r[0]   <= rpos_r && (ad < {2'b00, ra_r});
      flrd_r[0] <= flra_r;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [NW-1:0] trial;
    logic          ge;
    assign trial = NW'(rd_r[j]) << B;
    assign ge    = (rem_r[j] >= trial);

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem_r[j+1]  <= ge ? (rem_r[j] - trial) : rem_r[j];
        q_r[j+1]    <= ge ? (q_r[j] | (QW'(1) << B)) : q_r[j];
        rd_r[j+1]   <= rd_r[j];
        ok_r[j+1]   <= ok_r[j];
        flrd_r[j+1] <= flrd_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j+1] <= 1'b0;
      end else if (ctl.adv) begin
        vd_r[j+1] <= vd_r[j];
      end
    end
  end

  // ROM lookup, multiply, add
  fnv_t          v_r;
  flr_t          flrv_r;
  logic [33:0]   p_r;
  flr_t          flrp_r;
  logic          vv_r;
  logic          vp_r;
  logic          vo_r;
  viab_t         viab_r;
  logic [16:0]   sub_w;
  logic [33:0]   sh_w;
  logic signed [18:0] sum_w;

  assign sub_w = 17'(18'sd32768 - 18'(flrv_r));
  assign sh_w  = (p_r + 34'd16384) >> 15;
  assign sum_w = 19'(flrp_r) + $signed({2'b00, sh_w[16:0]});

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      v_r    <= ok_r[QW] ? FN_ROM[q_r[QW]] : '0;
      flrv_r <= flrd_r[QW];
      p_r    <= 34'(v_r) * 34'(sub_w);
      flrp_r <= flrv_r;
      viab_r <= sum_w[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vd_r[0] <= 1'b0;
      vv_r    <= 1'b0;
      vp_r    <= 1'b0;
      vo_r    <= 1'b0;
    end else if (ctl.adv) begin
      va_r    <= ctl.vld;
      vd_r[0] <= va_r;
      vv_r    <= vd_r[QW];
      vp_r    <= vv_r;
      vo_r    <= vp_r;
    end
  end

  assign vld  = vo_r;
  assign viab = viab_r;

endmodule

// ===== hdl/plant_viability_evaluator_unit.sv =====
// Plant viability evaluator, top level: parameter banks, four lanes, minimum.
// An evaluate item passes from its accepting edge through the input register, the
// stages of each lane with their one-bit-per-stage divider, and the output register.
// Throughput: one item per cycle while the output is not stalled.
// The whole pipeline stalls together while a result waits at the output register.
// Reset (synchronous, rst_n low) clears valid bits only; parameter banks are
// undefined until loaded.
module plant_viability_evaluator_unit import pve_pkg::*; #(
  parameter int NUM_SPECIES    = 64,
  parameter int FN_TABLE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  pve_in_if.sink    in_chan,
  pve_out_if.source out_chan
);

  localparam int AW = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;

  logic adv;
  logic acc;
  logic sp_ok;
  logic [15:0] sp_ext;

  assign adv           = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = adv;
  assign acc           = in_chan.valid && adv;
  assign sp_ok         = (32'(in_chan.species) < NUM_SPECIES);
  assign sp_ext        = 16'(in_chan.species);

  // one bank per parameter word, all read together on an item
  meas_t rd [NUM_SEL];

  for (genvar b = 0; b < NUM_SEL; b++) begin : g_bank
    logic we;
    assign we = acc && (in_chan.opcode == OP_LOAD) && sp_ok
                && (in_chan.param_select == 3'(b));
    pve_ram #(.WIDTH(24), .DEPTH(NUM_SPECIES)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (sp_ext[AW-1:0]),
      .wdata (in_chan.param_value),
      .re    (acc),
      .raddr (sp_ext[AW-1:0]),
      .rdata (rd[b])
    );
  end

  meas_t x_r [NUM_RES];
  flr_t  flr_r;
  logic  spok_r;
  logic  v1_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      x_r[0] <= in_chan.sunlight;
      x_r[1] <= in_chan.moisture;
      x_r[2] <= in_chan.temperature;
      x_r[3] <= in_chan.terrain_slope;
      flr_r  <= in_chan.stress_floor;
      spok_r <= sp_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_chan.valid && (in_chan.opcode == OP_EVAL);
    end
  end

  pve_ctl_t ctl;
  assign ctl.adv = adv;
  assign ctl.vld = v1_r;

  logic  lvld [NUM_RES];
  viab_t lv   [NUM_RES];

  for (genvar j = 0; j < NUM_RES; j++) begin : g_lane
    meas_t cc;
    meas_t rr;
    assign cc = spok_r ? rd[2*j]   : '0;
    assign rr = spok_r ? rd[2*j+1] : '0;
    pve_lane #(.FN_TABLE_DEPTH(FN_TABLE_DEPTH)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .x     (x_r[j]),
      .c     (cc),
      .r     (rr),
      .flr   (flr_r),
      .vld   (lvld[j]),
      .viab  (lv[j])
    );
  end

  viab_t m01;
  viab_t m23;
  viab_t mall;
  assign m01  = (lv[1] < lv[0]) ? lv[1] : lv[0];
  assign m23  = (lv[3] < lv[2]) ? lv[3] : lv[2];
  assign mall = (m23 < m01) ? m23 : m01;

  logic  ov_r;
  viab_t o_r [NUM_RES+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NUM_RES; j++) o_r[j] <= lv[j];
      o_r[NUM_RES] <= mall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= lvld[0];
    end
  end

  assign out_chan.valid                 = ov_r;
  assign out_chan.sun_viability         = o_r[0];
  assign out_chan.moisture_viability    = o_r[1];
  assign out_chan.temperature_viability = o_r[2];
  assign out_chan.slope_viability       = o_r[3];
  assign out_chan.least_viability       = o_r[NUM_RES];

endmodule

// ===== hdl/pve_checker.sv =====
// Port-level checks on the evaluator, bound to the top level.
// Depends on pve_pkg and plant_viability_evaluator_unit.
module pve_checker import pve_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input viab_t sun,
  input viab_t moist,
  input viab_t temp,
  input viab_t slope,
  input viab_t least
);

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input not ready with output empty");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(least) && $stable(sun))
    else $error("result changed while stalled");

  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (least <= sun) && (least <= moist) && (least <= temp) && (least <= slope))
    else $error("least above a viability");

  a_min_member: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (least == sun) || (least == moist) || (least == temp) || (least == slope))
    else $error("least is none of the viabilities");

endmodule

bind plant_viability_evaluator_unit pve_checker u_pve_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .sun       (out_chan.sun_viability),
  .moist     (out_chan.moisture_viability),
  .temp      (out_chan.temperature_viability),
  .slope     (out_chan.slope_viability),
  .least     (out_chan.least_viability)
);
